### sv/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    // Permutation geometry.
    localparam int SboxDepth = 256;
    localparam int AddrW     = 8;
    localparam int ByteW     = 8;

    // Key storage: two 64-bit registers, up to sixteen key bytes.
    localparam int RegW      = 64;
    localparam int KeyW      = 2 * RegW;
    localparam int KidxW     = 4;
    localparam int KeyLenDef = 16;

    // Configuration register select (paddr bit 3).
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [ByteW-1:0] data_in;
        logic             first_byte;
        logic             last_in;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] data_out;
        logic             last_out;
    } t_out_item;

    // Request from the sequencer to the permutation memory.
    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [ByteW-1:0] wdata;
        logic [AddrW-1:0] raddr;
    } t_sbox_req;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_K_RN,
        ST_K_RA,
        ST_K_WN,
        ST_K_WA,
        ST_G_RI,
        ST_G_RJ,
        ST_G_WI,
        ST_G_WJ,
        ST_G_OUT
    } t_state;

endpackage

`default_nettype wire

### sv/rc4_stream_cipher.sv
// RC4 stream cipher, one output item per input item.
// A new item is taken only in the idle state, after the last one is loaded
// into the output register; the sequencer reads i, reads j, writes i, writes j
// with the keystream read, then loads the output once it is free. An item with
// first_byte adds an identity fill and the key schedule (four memory accesses
// per keyed swap) before its generator step. Reset is synchronous: keys clear
// to zero and a fill writes the identity permutation, with input stalled until it completes.
`default_nettype none

module rc4_stream_cipher #(
    parameter int KEY_LEN = rc4_pkg::KeyLenDef
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire rc4_pkg::t_in_item         i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output rc4_pkg::t_out_item             o_out_item,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [3:0]                paddr,
    input  wire logic [rc4_pkg::RegW-1:0]  pwdata,
    output logic [rc4_pkg::RegW-1:0]       prdata,
    output logic                           pready
);
    import rc4_pkg::*;

    logic [RegW-1:0]  r_key_low;
    logic [RegW-1:0]  r_key_high;
    logic             cfg_write;
    t_sbox_req        sbox_req;
    logic [ByteW-1:0] sbox_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3])
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_KEY_HIGH: r_key_high <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[3])
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = r_key_high;
            default:      prdata = '0;
        endcase
    end

    rc4_ctrl #(
        .KEY_LEN (KEY_LEN)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        ({r_key_high, r_key_low}),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .o_sbox_req   (sbox_req),
        .i_sbox_rdata (sbox_rdata)
    );

    rc4_sbox u_sbox (
        .i_clk   (i_clk),
        .i_req   (sbox_req),
        .o_rdata (sbox_rdata)
    );

endmodule

`default_nettype wire

### sv/rc4_sbox.sv
`default_nettype none

module rc4_sbox (
    input  wire logic                    i_clk,
    input  wire rc4_pkg::t_sbox_req      i_req,
    output logic [rc4_pkg::ByteW-1:0]    o_rdata
);
    import rc4_pkg::*;

    logic [ByteW-1:0] r_mem [SboxDepth];
    logic [ByteW-1:0] r_rdata;

    // Single write port, single registered read port; a read returns old data
    // when it hits the address written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/rc4_ctrl.sv
`default_nettype none

module rc4_ctrl #(
    parameter int KEY_LEN = rc4_pkg::KeyLenDef
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [rc4_pkg::KeyW-1:0] i_key,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire rc4_pkg::t_in_item       i_in_item,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output rc4_pkg::t_out_item           o_out_item,
    output rc4_pkg::t_sbox_req           o_sbox_req,
    input  wire logic [rc4_pkg::ByteW-1:0] i_sbox_rdata
);
    import rc4_pkg::*;

    // Key length clamped into the supported range.
    localparam int EffKeyLen = (KEY_LEN < 1) ? 1 : ((KEY_LEN > 16) ? 16 : KEY_LEN);
    localparam logic [KidxW-1:0] KidxLast = KidxW'(EffKeyLen - 1);
    localparam logic [AddrW-1:0] AddrLast = AddrW'(SboxDepth - 1);

    t_state           r_state, n_state;
    logic             r_ksa;
    logic [AddrW-1:0] r_n;
    logic [KidxW-1:0] r_kidx;
    logic [ByteW-1:0] r_acc;
    logic [AddrW-1:0] r_i;
    logic [AddrW-1:0] r_j;
    logic [ByteW-1:0] r_si;
    logic [ByteW-1:0] r_sj;
    logic             r_fwd;
    logic [ByteW-1:0] r_data;
    logic             r_last;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_accept;
    logic             out_free;
    logic             load_out;
    logic [ByteW-1:0] key_byte;
    logic [ByteW-1:0] acc_sum;
    logic [AddrW-1:0] ks_addr;
    logic [ByteW-1:0] ks;
    t_sbox_req        sbox_req;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign key_byte  = i_key[{r_kidx, 3'b000} +: ByteW];
    assign acc_sum   = r_acc + i_sbox_rdata + key_byte;
    assign ks_addr   = r_si + r_sj;
    // The keystream read shares a cycle with the write of sbox[j]; take the
    // new value directly when it lands on j.
    assign ks        = r_fwd ? r_si : i_sbox_rdata;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (r_n == AddrLast) begin
                    n_state = r_ksa ? ST_K_RN : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = i_in_item.first_byte ? ST_FILL : ST_G_RI;
                end
            end
            ST_K_RN: n_state = ST_K_RA;
            ST_K_RA: n_state = ST_K_WN;
            ST_K_WN: n_state = ST_K_WA;
            ST_K_WA: n_state = (r_n == AddrLast) ? ST_G_RI : ST_K_RN;
            ST_G_RI: n_state = ST_G_RJ;
            ST_G_RJ: n_state = ST_G_WI;
            ST_G_WI: n_state = ST_G_WJ;
            ST_G_WJ: n_state = ST_G_OUT;
            ST_G_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory requests and handshake outputs for each state.
    always_comb begin
        sbox_req   = '0;
        o_in_stall = (r_state != ST_IDLE);
        load_out   = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = r_n;
                sbox_req.wdata = r_n;
            end
            ST_K_RN: sbox_req.raddr = r_n;
            ST_K_RA: sbox_req.raddr = acc_sum;
            ST_K_WN: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = r_n;
                sbox_req.wdata = i_sbox_rdata;
            end
            ST_K_WA: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = r_acc;
                sbox_req.wdata = r_si;
            end
            ST_G_RI: sbox_req.raddr = r_i + 1'b1;
            ST_G_RJ: sbox_req.raddr = r_j + i_sbox_rdata;
            ST_G_WI: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = r_i;
                sbox_req.wdata = i_sbox_rdata;
            end
            ST_G_WJ: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = r_j;
                sbox_req.wdata = r_si;
                sbox_req.raddr = ks_addr;
            end
            ST_G_OUT: begin
                // Keep reading the keystream entry so it holds while the output waits.
                sbox_req.raddr = ks_addr;
                load_out       = out_free;
            end
            default: ;
        endcase
    end

    // Control state and indices.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ksa       <= 1'b0;
            r_n         <= '0;
            r_kidx      <= '0;
            r_acc       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_FILL: begin
                    r_n    <= r_n + 1'b1;
                    r_acc  <= '0;
                    r_kidx <= '0;
                    if (r_n == AddrLast) begin
                        r_ksa <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (in_accept && i_in_item.first_byte) begin
                        r_ksa <= 1'b1;
                        r_i   <= '0;
                        r_j   <= '0;
                    end
                end
                ST_K_RA: r_acc <= acc_sum;
                ST_K_WA: begin
                    r_n    <= r_n + 1'b1;
                    r_kidx <= (r_kidx == KidxLast) ? '0 : r_kidx + 1'b1;
                end
                ST_G_RI: r_i <= r_i + 1'b1;
                ST_G_RJ: r_j <= r_j + i_sbox_rdata;
                default: ;
            endcase
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data <= i_in_item.data_in;
            r_last <= i_in_item.last_in;
        end
        if (r_state == ST_K_RA || r_state == ST_G_RJ) begin
            r_si <= i_sbox_rdata;
        end
        if (r_state == ST_G_WI) begin
            r_sj <= i_sbox_rdata;
        end
        if (r_state == ST_G_WJ) begin
            r_fwd <= (ks_addr == r_j);
        end
        if (load_out) begin
            r_out.data_out <= r_data ^ ks;
            r_out.last_out <= r_last;
        end
    end

    assign o_sbox_req  = sbox_req;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The permutation is never written while an item may be accepted.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !sbox_req.we)
        else $error("sbox written while idle");

    // A first byte always starts with a fresh identity fill.
    a_first_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.first_byte) |=> (r_state == ST_FILL && r_n == '0))
        else $error("first byte did not start key schedule");

    // The key schedule ends in the generator with cleared indices.
    a_ksa_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_K_WA && r_n == AddrLast)
            |=> (r_state == ST_G_RI && r_i == '0 && r_j == '0))
        else $error("key schedule exit wrong");

    // A finished item leaves the generator only into the output register.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G_OUT && n_state == ST_IDLE) |=> r_out_valid)
        else $error("result lost");

endmodule

`default_nettype wire
